[hdl/agffa_pkg.sv]
// Shared types and constants of the atlas grid first-fit allocator.
package agffa_pkg;

  // Grid capacity of the occupancy bitmap
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int COL_IDX_W   = $clog2(MAX_COLUMNS);
  localparam int COL_CNT_W   = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_IDX_W   = $clog2(MAX_ROWS);
  localparam int ROW_CNT_W   = $clog2(MAX_ROWS + 1);

  // Field widths
  localparam int IMG_W  = 13;
  localparam int CP_W   = 9;
  localparam int GRID_W = 7;
  localparam int CELL_W = 6;
  localparam int PIX_W  = 14;
  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  // Cell index times cell size, before saturation
  localparam int PROD_W = CELL_W + CP_W;

  // Shared restoring divider: dividend is size + cell - 1
  localparam int DVD_W     = IMG_W + 1;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration channel
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CP_W;

  // Command queue
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_PIXELS  = 2'd0,
    REG_GRID_COLUMNS = 2'd1,
    REG_GRID_ROWS    = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_FAIL = 2'd0,
    CMD_ZERO = 2'd1,
    CMD_SCAN = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [CP_W-1:0]   cell_pixels;
    logic [GRID_W-1:0] grid_columns;
    logic [GRID_W-1:0] grid_rows;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [COL_CNT_W-1:0]  req_w;
    logic [ROW_CNT_W-1:0]  req_h;
    logic [COL_CNT_W-1:0]  cols;
    logic [ROW_CNT_W-1:0]  rows;
    logic [CP_W-1:0]       cell_pixels;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

[hdl/agffa_ifs.sv]
// Handshake interfaces: request, response and configuration write channels.
interface agffa_req_if;
  logic                       valid;
  logic                       ready;
  logic [agffa_pkg::IMG_W-1:0] image_width;
  logic [agffa_pkg::IMG_W-1:0] image_height;

  modport source (output valid, output image_width, output image_height, input ready);
  modport sink   (input valid, input image_width, input image_height, output ready);
endinterface

interface agffa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        placed;
  logic [agffa_pkg::CELL_W-1:0] cell_col;
  logic [agffa_pkg::CELL_W-1:0] cell_row;
  logic [agffa_pkg::PIX_W-1:0]  pixel_x;
  logic [agffa_pkg::PIX_W-1:0]  pixel_y;

  modport source (output valid, output placed, output cell_col, output cell_row,
                  output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input placed, input cell_col, input cell_row,
                  input pixel_x, input pixel_y, output ready);
endinterface

interface agffa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [agffa_pkg::CFG_IDX_W-1:0]  index;
  logic [agffa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/agffa_front.sv]
// Front end: accepts requests, rounds sizes to cells, classifies into commands.
module agffa_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  agffa_req_if.sink                req_i,
  input  agffa_pkg::cfg_t          cfg_i,
  output logic                     push_o,
  output agffa_pkg::cmd_t          cmd_o,
  input  agffa_pkg::fifo_status_t  fifo_i
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;

  logic [agffa_pkg::DVD_W-1:0]     qr_q, qr_d;
  logic [agffa_pkg::CP_W-1:0]      rem_q, rem_d;
  logic [agffa_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                            second_q, second_d;
  logic [agffa_pkg::DVD_W-1:0]     reqw_q, reqw_d;
  logic [agffa_pkg::IMG_W-1:0]     h_px_q, h_px_d;
  agffa_pkg::cmd_t                 cmd_q, cmd_d;

  logic [agffa_pkg::CP_W:0]        rem_sh;
  logic                            ge;
  logic [agffa_pkg::CP_W:0]        rem_sub;
  logic [agffa_pkg::COL_CNT_W-1:0] cols_c;
  logic [agffa_pkg::ROW_CNT_W-1:0] rows_c;
  logic [agffa_pkg::DVD_W-1:0]     reqh;

  // Clamp the grid registers to the bitmap size
  always_comb begin
    if (cfg_i.grid_columns > agffa_pkg::GRID_W'(agffa_pkg::MAX_COLUMNS)) begin
      cols_c = agffa_pkg::COL_CNT_W'(agffa_pkg::MAX_COLUMNS);
    end else begin
      cols_c = agffa_pkg::COL_CNT_W'(cfg_i.grid_columns);
    end
    if (cfg_i.grid_rows > agffa_pkg::GRID_W'(agffa_pkg::MAX_ROWS)) begin
      rows_c = agffa_pkg::ROW_CNT_W'(agffa_pkg::MAX_ROWS);
    end else begin
      rows_c = agffa_pkg::ROW_CNT_W'(cfg_i.grid_rows);
    end
  end

  // One restoring division step per cycle
  assign rem_sh  = {rem_q, qr_q[agffa_pkg::DVD_W-1]};
  assign ge      = (rem_sh >= {1'b0, cfg_i.cell_pixels});
  assign rem_sub = rem_sh - {1'b0, cfg_i.cell_pixels};
  assign reqh    = {qr_q[agffa_pkg::DVD_W-2:0], ge};

  always_comb begin
    state_d  = state_q;
    qr_d     = qr_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    second_d = second_q;
    reqw_d   = reqw_q;
    h_px_d   = h_px_q;
    cmd_d    = cmd_q;

    case (state_q)
      F_IDLE: begin
        if (req_i.valid) begin
          cmd_d.cell_pixels = cfg_i.cell_pixels;
          cmd_d.cols        = cols_c;
          cmd_d.rows        = rows_c;
          cmd_d.req_w       = '0;
          cmd_d.req_h       = '0;
          h_px_d            = req_i.image_height;
          if (cfg_i.cell_pixels == '0) begin
            cmd_d.kind = agffa_pkg::CMD_FAIL;
            state_d    = F_PUSH;
          end else begin
            qr_d     = agffa_pkg::DVD_W'(req_i.image_width)
                     + agffa_pkg::DVD_W'(cfg_i.cell_pixels) - agffa_pkg::DVD_W'(1);
            rem_d    = '0;
            cnt_d    = '0;
            second_d = 1'b0;
            state_d  = F_DIV;
          end
        end
      end
      F_DIV: begin
        rem_d = ge ? rem_sub[agffa_pkg::CP_W-1:0] : rem_sh[agffa_pkg::CP_W-1:0];
        qr_d  = reqh;
        cnt_d = cnt_q + agffa_pkg::DIV_CNT_W'(1);
        if (cnt_q == agffa_pkg::DIV_CNT_W'(agffa_pkg::DIV_STEPS - 1)) begin
          if (!second_q) begin
            // width done, start on the height
            reqw_d   = reqh;
            second_d = 1'b1;
            qr_d     = agffa_pkg::DVD_W'(h_px_q)
                     + agffa_pkg::DVD_W'(cfg_i.cell_pixels) - agffa_pkg::DVD_W'(1);
            rem_d    = '0;
            cnt_d    = '0;
          end else begin
            if (reqw_q > agffa_pkg::DVD_W'(cmd_q.cols) ||
                reqh > agffa_pkg::DVD_W'(cmd_q.rows)) begin
              cmd_d.kind = agffa_pkg::CMD_FAIL;
            end else if (reqw_q == '0 || reqh == '0) begin
              cmd_d.kind = agffa_pkg::CMD_ZERO;
            end else begin
              cmd_d.kind = agffa_pkg::CMD_SCAN;
            end
            cmd_d.req_w = reqw_q[agffa_pkg::COL_CNT_W-1:0];
            cmd_d.req_h = reqh[agffa_pkg::ROW_CNT_W-1:0];
            state_d     = F_PUSH;
          end
        end
      end
      F_PUSH: begin
        if (!fifo_i.full) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      cnt_q    <= '0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qr_q   <= qr_d;
    rem_q  <= rem_d;
    reqw_q <= reqw_d;
    h_px_q <= h_px_d;
    cmd_q  <= cmd_d;
  end

  assign req_i.ready = (state_q == F_IDLE);
  assign push_o      = (state_q == F_PUSH) && !fifo_i.full;
  assign cmd_o       = cmd_q;

endmodule

[hdl/agffa_cmd_fifo.sv]
// Short command queue between the front end and the scan engine.
module agffa_cmd_fifo (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  agffa_pkg::cmd_t          data_i,
  input  logic                     pop_i,
  output agffa_pkg::cmd_t          data_o,
  output agffa_pkg::fifo_status_t  status_o
);

  agffa_pkg::cmd_t                 entry_q [agffa_pkg::CMD_DEPTH];
  logic [agffa_pkg::CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [agffa_pkg::CMD_CNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == agffa_pkg::CMD_PTR_W'(agffa_pkg::CMD_DEPTH - 1)) ?
                    '0 : wr_ptr_q + agffa_pkg::CMD_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == agffa_pkg::CMD_PTR_W'(agffa_pkg::CMD_DEPTH - 1)) ?
                    '0 : rd_ptr_q + agffa_pkg::CMD_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + agffa_pkg::CMD_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - agffa_pkg::CMD_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = entry_q[rd_ptr_q];
  assign status_o.full  = (count_q == agffa_pkg::CMD_CNT_W'(agffa_pkg::CMD_DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

[hdl/agffa_back.sv]
// Scan engine: occupancy bitmap, first-fit search, region marking, result register.
module agffa_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  agffa_pkg::cmd_t          cmd_i,
  input  agffa_pkg::fifo_status_t  fifo_i,
  output logic                     pop_o,
  agffa_rsp_if.source              rsp_o
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_ACC  = 4'b0010,
    B_SCAN = 4'b0100,
    B_MARK = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;

  // Bitmap: one word per cell row, plus a valid bit per row cleared at reset
  logic [agffa_pkg::MAX_COLUMNS-1:0] occ_mem [agffa_pkg::MAX_ROWS];
  logic [agffa_pkg::MAX_ROWS-1:0]    row_valid_q;
  logic [agffa_pkg::MAX_COLUMNS-1:0] rd_data_q;
  logic                              rd_valid_q;
  logic [agffa_pkg::MAX_COLUMNS-1:0] rd_eff;

  logic                              rd_en, wr_en;
  logic [agffa_pkg::ROW_IDX_W-1:0]   rd_addr, wr_addr;
  logic [agffa_pkg::MAX_COLUMNS-1:0] wr_data;

  agffa_pkg::cmd_t                   cmd_q, cmd_d;
  logic [agffa_pkg::ROW_IDX_W-1:0]   r_q, r_d;
  logic [agffa_pkg::ROW_CNT_W-1:0]   k_q, k_d;
  logic                              pend_q, pend_d;
  logic [agffa_pkg::MAX_COLUMNS-1:0] or_q, or_d;
  logic [agffa_pkg::COL_CNT_W-1:0]   pos_q, pos_d;
  logic [agffa_pkg::COL_CNT_W-1:0]   run_q, run_d;
  logic [agffa_pkg::COL_IDX_W-1:0]   col_q, col_d;
  logic [agffa_pkg::MAX_COLUMNS-1:0] lmask_q, lmask_d;
  logic [agffa_pkg::MAX_COLUMNS-1:0] mask_q, mask_d;
  logic [agffa_pkg::ROW_IDX_W-1:0]   wa_q, wa_d;

  logic                              rsp_valid_q, rsp_valid_d;
  logic                              res_placed_q, res_placed_d;
  logic [agffa_pkg::CELL_W-1:0]      res_col_q, res_col_d;
  logic [agffa_pkg::CELL_W-1:0]      res_row_q, res_row_d;
  logic [agffa_pkg::PIX_W-1:0]       res_px_q, res_px_d;
  logic [agffa_pkg::PIX_W-1:0]       res_py_q, res_py_d;

  logic                              issue;
  logic [agffa_pkg::COL_CNT_W-1:0]   run_n;
  logic [agffa_pkg::COL_IDX_W-1:0]   col_new;
  logic [agffa_pkg::ROW_CNT_W:0]     next_end;
  logic                              finish, fin_placed;
  logic [agffa_pkg::COL_IDX_W-1:0]   fin_col;
  logic [agffa_pkg::ROW_IDX_W-1:0]   fin_row;
  logic [agffa_pkg::PROD_W-1:0]      prod_x, prod_y;

  assign rd_eff  = rd_valid_q ? rd_data_q : '0;
  assign issue   = (k_q < cmd_q.req_h);
  assign rd_addr = r_q + k_q[agffa_pkg::ROW_IDX_W-1:0];
  assign wr_addr = wa_q;
  assign wr_data = rd_eff | mask_q;

  assign run_n    = or_q[pos_q[agffa_pkg::COL_IDX_W-1:0]] ? '0
                  : run_q + agffa_pkg::COL_CNT_W'(1);
  assign col_new  = agffa_pkg::COL_IDX_W'(pos_q + agffa_pkg::COL_CNT_W'(1) - cmd_q.req_w);
  assign next_end = (agffa_pkg::ROW_CNT_W+1)'(r_q) + (agffa_pkg::ROW_CNT_W+1)'(1)
                  + (agffa_pkg::ROW_CNT_W+1)'(cmd_q.req_h);

  // Pixel origin, saturated
  assign prod_x = agffa_pkg::PROD_W'(fin_col) * agffa_pkg::PROD_W'(cmd_q.cell_pixels);
  assign prod_y = agffa_pkg::PROD_W'(fin_row) * agffa_pkg::PROD_W'(cmd_q.cell_pixels);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    r_d        = r_q;
    k_d        = k_q;
    pend_d     = 1'b0;
    or_d       = or_q;
    pos_d      = pos_q;
    run_d      = run_q;
    col_d      = col_q;
    lmask_d    = lmask_q;
    mask_d     = mask_q;
    wa_d       = wa_q;
    pop_o      = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    finish     = 1'b0;
    fin_placed = 1'b0;
    fin_col    = col_q;
    fin_row    = r_q;

    case (state_q)
      B_IDLE: begin
        if (!fifo_i.empty && !rsp_valid_q) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          r_d     = '0;
          k_d     = '0;
          or_d    = '0;
          lmask_d = {agffa_pkg::MAX_COLUMNS{1'b1}} >>
                    (agffa_pkg::COL_CNT_W'(agffa_pkg::MAX_COLUMNS) - cmd_i.req_w);
          case (cmd_i.kind)
            agffa_pkg::CMD_SCAN: begin
              state_d = B_ACC;
            end
            agffa_pkg::CMD_ZERO: begin
              finish     = 1'b1;
              fin_placed = 1'b1;
              fin_col    = '0;
              fin_row    = '0;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      B_ACC: begin
        // OR together the rows under the candidate region
        if (issue) begin
          rd_en  = 1'b1;
          k_d    = k_q + agffa_pkg::ROW_CNT_W'(1);
          pend_d = 1'b1;
        end
        if (pend_q) begin
          or_d = or_q | rd_eff;
        end
        if (!issue && !pend_q) begin
          pos_d   = '0;
          run_d   = '0;
          state_d = B_SCAN;
        end
      end
      B_SCAN: begin
        // one column per cycle, tracking the free run
        run_d = run_n;
        pos_d = pos_q + agffa_pkg::COL_CNT_W'(1);
        if (run_n == cmd_q.req_w) begin
          col_d   = col_new;
          mask_d  = lmask_q << col_new;
          k_d     = '0;
          state_d = B_MARK;
        end else if (pos_q + agffa_pkg::COL_CNT_W'(1) == cmd_q.cols) begin
          if (next_end > (agffa_pkg::ROW_CNT_W+1)'(cmd_q.rows)) begin
            finish  = 1'b1;
            state_d = B_IDLE;
          end else begin
            r_d     = r_q + agffa_pkg::ROW_IDX_W'(1);
            k_d     = '0;
            or_d    = '0;
            state_d = B_ACC;
          end
        end
      end
      B_MARK: begin
        // read-modify-write, read of next row overlaps write of previous
        if (issue) begin
          rd_en  = 1'b1;
          k_d    = k_q + agffa_pkg::ROW_CNT_W'(1);
          pend_d = 1'b1;
          wa_d   = rd_addr;
        end
        if (pend_q) begin
          wr_en = 1'b1;
        end
        if (!issue && !pend_q) begin
          finish     = 1'b1;
          fin_placed = 1'b1;
          state_d    = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // Result register
  always_comb begin
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    res_placed_d = res_placed_q;
    res_col_d    = res_col_q;
    res_row_d    = res_row_q;
    res_px_d     = res_px_q;
    res_py_d     = res_py_q;
    if (finish) begin
      rsp_valid_d  = 1'b1;
      res_placed_d = fin_placed;
      if (fin_placed) begin
        res_col_d = agffa_pkg::CELL_W'(fin_col);
        res_row_d = agffa_pkg::CELL_W'(fin_row);
        res_px_d  = (prod_x > agffa_pkg::PROD_W'(agffa_pkg::PIX_MAX)) ? agffa_pkg::PIX_MAX
                  : prod_x[agffa_pkg::PIX_W-1:0];
        res_py_d  = (prod_y > agffa_pkg::PROD_W'(agffa_pkg::PIX_MAX)) ? agffa_pkg::PIX_MAX
                  : prod_y[agffa_pkg::PIX_W-1:0];
      end else begin
        res_col_d = '0;
        res_row_d = '0;
        res_px_d  = '0;
        res_py_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      occ_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= occ_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      pend_q      <= 1'b0;
      k_q         <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      k_q     <= k_d;
      rsp_valid_q <= rsp_valid_d;
      if (wr_en) begin
        row_valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= row_valid_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    r_q          <= r_d;
    or_q         <= or_d;
    pos_q        <= pos_d;
    run_q        <= run_d;
    col_q        <= col_d;
    lmask_q      <= lmask_d;
    mask_q       <= mask_d;
    wa_q         <= wa_d;
    res_placed_q <= res_placed_d;
    res_col_q    <= res_col_d;
    res_row_q    <= res_row_d;
    res_px_q     <= res_px_d;
    res_py_q     <= res_py_d;
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.placed   = res_placed_q;
  assign rsp_o.cell_col = res_col_q;
  assign rsp_o.cell_row = res_row_q;
  assign rsp_o.pixel_x  = res_px_q;
  assign rsp_o.pixel_y  = res_py_q;

endmodule

[hdl/atlas_grid_first_fit_allocator_core.sv]
// Top level of the atlas grid first-fit allocator.
//
// Usage:
//   req_i carries one word per image: width and height in pixels. rsp_o
//   returns one word per request: placed flag, top-left cell and pixel origin
//   (all zero when not placed). cfg_i writes cell_pixels (index 0),
//   grid_columns (1) and grid_rows (2); it is always ready and must only be
//   used while no request is in flight.
// Operation:
//   Front end: accepts a request, divides width then height (14 divider
//   steps each) and pushes the command, waiting while the queue is full.
//   Scan engine, per candidate row: ORs the rows under it (one bitmap read
//   per cycle), then walks the columns. Marking reads and rewrites each row
//   of the region; failed/zero requests go straight to the result register.
//   One request scans at a time; two more wait in the queue, one in the front.
// Reset:
//   Bitmap reads as all free through per-row valid bits, so there is no
//   clearing pass; config registers return to 16 / 64 / 64.
// Stall:
//   A result holds in the output register until taken; the front end keeps
//   accepting and queuing requests meanwhile, until the queue is full.
module atlas_grid_first_fit_allocator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  agffa_req_if.sink    req_i,
  agffa_rsp_if.source  rsp_o,
  agffa_cfg_if.sink    cfg_i
);

  agffa_pkg::cfg_t          cfg_q;
  agffa_pkg::cmd_t          push_cmd, pop_cmd;
  agffa_pkg::fifo_status_t  fifo_status;
  logic                     push, pop;

  // Config registers; writes past the list are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_pixels  <= agffa_pkg::CP_W'(16);
      cfg_q.grid_columns <= agffa_pkg::GRID_W'(64);
      cfg_q.grid_rows    <= agffa_pkg::GRID_W'(64);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        agffa_pkg::REG_CELL_PIXELS: begin
          cfg_q.cell_pixels <= cfg_i.data[agffa_pkg::CP_W-1:0];
        end
        agffa_pkg::REG_GRID_COLUMNS: begin
          cfg_q.grid_columns <= cfg_i.data[agffa_pkg::GRID_W-1:0];
        end
        agffa_pkg::REG_GRID_ROWS: begin
          cfg_q.grid_rows <= cfg_i.data[agffa_pkg::GRID_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  agffa_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cfg_i  (cfg_q),
    .push_o (push),
    .cmd_o  (push_cmd),
    .fifo_i (fifo_status)
  );

  agffa_cmd_fifo u_cmd_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_cmd),
    .pop_i    (pop),
    .data_o   (pop_cmd),
    .status_o (fifo_status)
  );

  agffa_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (pop_cmd),
    .fifo_i (fifo_status),
    .pop_o  (pop),
    .rsp_o  (rsp_o)
  );

endmodule

[hdl/agffa_checker.sv]
// Port-level checker for the allocator, bound to the top level.
module agffa_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  agffa_req_if.sink    req_i,
  agffa_rsp_if.source  rsp_o
);

  // words accepted but not yet answered
  logic [2:0] outstanding_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      case ({req_i.valid && req_i.ready, rsp_o.valid && rsp_o.ready})
        2'b10:   outstanding_q <= outstanding_q + 3'd1;
        2'b01:   outstanding_q <= outstanding_q - 3'd1;
        default: outstanding_q <= outstanding_q;
      endcase
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(rsp_o.placed) &&
    $stable(rsp_o.cell_col) && $stable(rsp_o.cell_row) &&
    $stable(rsp_o.pixel_x) && $stable(rsp_o.pixel_y))
    else $error("response changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> outstanding_q != 3'd0)
    else $error("response without a pending request");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= 3'd4)
    else $error("more requests in flight than the block can hold");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.placed |-> rsp_o.cell_col == '0 && rsp_o.cell_row == '0 &&
    rsp_o.pixel_x == '0 && rsp_o.pixel_y == '0)
    else $error("failed placement with nonzero origin");

endmodule

bind atlas_grid_first_fit_allocator_core agffa_checker u_agffa_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);

[test/testbench.sv]
// Self-checking testbench for the atlas grid first-fit allocator core.
`timescale 1ns / 1ps

module testbench;

  // Index that maps to no register; writes to it must leave the config alone
  localparam logic [agffa_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                         placed;
    logic [agffa_pkg::CELL_W-1:0] cell_col;
    logic [agffa_pkg::CELL_W-1:0] cell_row;
    logic [agffa_pkg::PIX_W-1:0]  pixel_x;
    logic [agffa_pkg::PIX_W-1:0]  pixel_y;
  } placement_t;

  // Scoreboard: shadow bitmap and config, first-fit predictor, result checker.
  class placement_book;
    bit                           taken [agffa_pkg::MAX_ROWS][agffa_pkg::MAX_COLUMNS];
    logic [agffa_pkg::CP_W-1:0]   cell_px;
    logic [agffa_pkg::GRID_W-1:0] grid_cols;
    logic [agffa_pkg::GRID_W-1:0] grid_rows;
    placement_t                   placements_due[$];
    int unsigned                  mismatch_count;
    int unsigned                  results_seen;

    function new();
      foreach (taken[r, c]) taken[r][c] = 1'b0;
      cell_px        = 9'd16;
      grid_cols      = 7'd64;
      grid_rows      = 7'd64;
      mismatch_count = 0;
      results_seen   = 0;
    endfunction

    function void write_register(logic [agffa_pkg::CFG_IDX_W-1:0] idx,
                                 logic [agffa_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        agffa_pkg::REG_CELL_PIXELS:  cell_px   = value;
        agffa_pkg::REG_GRID_COLUMNS: grid_cols = value[agffa_pkg::GRID_W-1:0];
        agffa_pkg::REG_GRID_ROWS:    grid_rows = value[agffa_pkg::GRID_W-1:0];
        default: ;
      endcase
    endfunction

    function bit area_free(int unsigned row, int unsigned col, int unsigned tall,
                           int unsigned wide);
      for (int unsigned dy = 0; dy < tall; dy++)
        for (int unsigned dx = 0; dx < wide; dx++)
          if (taken[row + dy][col + dx]) return 1'b0;
      return 1'b1;
    endfunction

    function logic [agffa_pkg::PIX_W-1:0] pixel_of(int unsigned cell_idx);
      int unsigned p;
      p = cell_idx * cell_px;
      return (p > agffa_pkg::PIX_MAX) ? agffa_pkg::PIX_MAX : p[agffa_pkg::PIX_W-1:0];
    endfunction

    // First fit, row-major scan; marks the region and queues the expected word.
    function void note_request(logic [agffa_pkg::IMG_W-1:0] w_px,
                               logic [agffa_pkg::IMG_W-1:0] h_px);
      placement_t  res;
      int unsigned cols, rows, wide, tall;
      bit          found;
      res   = '0;
      found = 1'b0;
      cols  = (grid_cols > agffa_pkg::MAX_COLUMNS) ? agffa_pkg::MAX_COLUMNS : grid_cols;
      rows  = (grid_rows > agffa_pkg::MAX_ROWS) ? agffa_pkg::MAX_ROWS : grid_rows;
      if (cell_px != 0) begin
        wide = (32'(w_px) + 32'(cell_px) - 1) / 32'(cell_px);
        tall = (32'(h_px) + 32'(cell_px) - 1) / 32'(cell_px);
        if (wide <= cols && tall <= rows) begin
          for (int unsigned r = 0; !found && r + tall <= rows; r++)
            for (int unsigned c = 0; !found && c + wide <= cols; c++)
              if (area_free(r, c, tall, wide)) begin
                found = 1'b1;
                for (int unsigned dy = 0; dy < tall; dy++)
                  for (int unsigned dx = 0; dx < wide; dx++)
                    taken[r + dy][c + dx] = 1'b1;
                res.placed   = 1'b1;
                res.cell_col = c[agffa_pkg::CELL_W-1:0];
                res.cell_row = r[agffa_pkg::CELL_W-1:0];
                res.pixel_x  = pixel_of(c);
                res.pixel_y  = pixel_of(r);
              end
        end
      end
      placements_due.push_back(res);
    endfunction

    function int unsigned pending();
      return placements_due.size();
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
      mismatch_count++;
    endtask

    task check_result(placement_t got);
      placement_t want;
      results_seen++;
      if (placements_due.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected (%h)", got));
        return;
      end
      want = placements_due.pop_front();
      if (got.placed !== want.placed)
        flag_mismatch($sformatf("placed %b, want %b", got.placed, want.placed));
      if (got.cell_col !== want.cell_col)
        flag_mismatch($sformatf("cell_col %0d, want %0d", got.cell_col, want.cell_col));
      if (got.cell_row !== want.cell_row)
        flag_mismatch($sformatf("cell_row %0d, want %0d", got.cell_row, want.cell_row));
      if (got.pixel_x !== want.pixel_x)
        flag_mismatch($sformatf("pixel_x %0d, want %0d", got.pixel_x, want.pixel_x));
      if (got.pixel_y !== want.pixel_y)
        flag_mismatch($sformatf("pixel_y %0d, want %0d", got.pixel_y, want.pixel_y));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   send_steady;   // when set, requests go back to back with no gaps

  placement_book sb;

  agffa_req_if req_if ();
  agffa_rsp_if rsp_if ();
  agffa_cfg_if cfg_if ();

  atlas_grid_first_fit_allocator_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 90);
  endfunction

  // Cell size per phase: the range ends, oversized values that saturate the
  // pixel origin, the zero that fails everything, and ordinary small sizes.
  function automatic logic [agffa_pkg::CFG_DATA_W-1:0] pick_cell_px();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 9'd1;
    if (r < 30) return 9'd256;
    if (r < 38) return 9'($urandom_range(257, 511));
    if (r < 42) return 9'd0;
    return 9'($urandom_range(2, 64));
  endfunction

  // Grid dimension: full, clamped (above 64), empty, single cell or random.
  // The two bits above the 7-bit register get noise; they must be dropped.
  function automatic logic [agffa_pkg::CFG_DATA_W-1:0] pick_grid();
    int unsigned r;
    logic [agffa_pkg::GRID_W-1:0] dim;
    r = $urandom_range(99);
    if (r < 20)      dim = 7'd64;
    else if (r < 28) dim = 7'($urandom_range(65, 127));
    else if (r < 32) dim = 7'd0;
    else if (r < 42) dim = 7'd1;
    else             dim = 7'($urandom_range(2, 64));
    return {2'($urandom_range(3)), dim};
  endfunction

  // Image edge in pixels: mostly a few whole cells with a random partial
  // last cell, plus zeros and raw 13-bit noise.
  function automatic logic [agffa_pkg::IMG_W-1:0] pixels_for(logic [agffa_pkg::CP_W-1:0] cp);
    int unsigned r, k, p;
    r = $urandom_range(99);
    if (r < 10) return 13'($urandom_range(0, 8191));
    if (r < 15) return '0;
    k = (r < 75) ? $urandom_range(1, 3) : $urandom_range(1, 12);
    if (cp == 0) return 13'(k);
    p = (k - 1) * cp + $urandom_range(1, cp);
    return (p > 8191) ? 13'd8191 : 13'(p);
  endfunction

  // Request side. All tasks start and end at a falling edge.
  task automatic pause_requests(int unsigned cycles);
    req_if.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic offer_image(input logic [agffa_pkg::IMG_W-1:0] w_px,
                             input logic [agffa_pkg::IMG_W-1:0] h_px);
    int unsigned gap;
    req_if.valid        <= 1'b1;
    req_if.image_width  <= w_px;
    req_if.image_height <= h_px;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_request(w_px, h_px);
    @(negedge clk);
    gap = send_steady ? 0 : idle_span();
    if (gap > 0) pause_requests(gap);
  endtask

  // Stop sending and wait until every queued placement has come back.
  task automatic settle();
    pause_requests(1);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [agffa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [agffa_pkg::CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    sb.write_register(idx, value);
    @(negedge clk);
  endtask

  // Config only changes with the block drained; the bitmap carries over.
  task automatic configure(input logic [agffa_pkg::CFG_DATA_W-1:0] cp,
                           input logic [agffa_pkg::CFG_DATA_W-1:0] cols,
                           input logic [agffa_pkg::CFG_DATA_W-1:0] rows,
                           input bit poke_unused);
    settle();
    write_reg(agffa_pkg::REG_CELL_PIXELS, cp);
    write_reg(agffa_pkg::REG_GRID_COLUMNS, cols);
    write_reg(agffa_pkg::REG_GRID_ROWS, rows);
    if (poke_unused) write_reg(REG_UNUSED, 9'h1FF);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Result side: ready in high bursts of random length, broken by gaps.
  initial begin
    int unsigned gap;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk) rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40) - 1) @(negedge clk);
      gap = idle_span();
      if (gap > 0) begin
        @(negedge clk) rsp_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  // Every accepted result word goes to the scoreboard.
  always @(posedge clk) begin
    placement_t got;
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.placed   = rsp_if.placed;
      got.cell_col = rsp_if.cell_col;
      got.cell_row = rsp_if.cell_row;
      got.pixel_x  = rsp_if.pixel_x;
      got.pixel_y  = rsp_if.pixel_y;
      sb.check_result(got);
    end
  end

  initial begin
    sb                  = new();
    send_steady         = 1'b0;
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.image_width  = '0;
    req_if.image_height = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = agffa_pkg::REG_CELL_PIXELS;
    cfg_if.data         = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset config (16 px cells, 64 x 64 grid), fresh empty bitmap.
    offer_image(13'd0, 13'd0);        // zero size: origin, nothing marked
    offer_image(13'd1, 13'd1);        // single cell at the origin
    offer_image(13'd1024, 13'd16);    // full-width strip, lands on row 1
    offer_image(13'd16, 13'd1024);    // full-height column: blocked everywhere
    offer_image(13'd1025, 13'd1);     // one column too wide
    offer_image(13'd0, 13'd4096);     // zero width but far too tall
    offer_image(13'd4096, 13'd0);     // zero height but far too wide
    offer_image(13'd8191, 13'd8191);  // all ones
    offer_image(13'd0, 13'd1024);     // zero width, height exactly fits
    offer_image(13'd17, 13'd33);      // partial cells round up to 2 x 3

    // One-pixel cells: a 40-wide strip fills most of row 0.
    configure(9'd1, 9'd64, 9'd64, 1'b0);
    offer_image(13'd40, 13'd1);
    offer_image(13'd64, 13'd64);
    offer_image(13'd1, 13'd1);

    // Oversized cells and clamped grid: the next free column saturates pixel_x.
    configure(9'd511, 9'd127, 9'd127, 1'b0);
    offer_image(13'd1, 13'd1);
    offer_image(13'd511, 13'd511);
    offer_image(13'd0, 13'd0);

    // Zero cell size: everything fails.
    configure(9'd0, 9'd64, 9'd64, 1'b0);
    offer_image(13'd0, 13'd0);
    offer_image(13'd5, 13'd5);

    // Empty grid; also a write to the unmapped index.
    configure(9'd256, 9'd0, 9'd0, 1'b1);
    offer_image(13'd0, 13'd0);
    offer_image(13'd0, 13'd300);
    offer_image(13'd1, 13'd1);

    // Single-cell grid whose only cell is already taken.
    configure(9'd256, 9'd1, 9'd1, 1'b0);
    offer_image(13'd0, 13'd0);
    offer_image(13'd256, 13'd256);

    // Random phases, each with its own config; the bitmap keeps filling.
    for (int p = 0; p < 6; p++) begin
      configure(pick_cell_px(), pick_grid(), pick_grid(), 1'b0);
      send_steady = ($urandom_range(3) == 0);
      for (int i = 0; i < 20; i++) begin
        if (p == 2 && i == 10) settle();  // hold off until the pipe is empty
        offer_image(pixels_for(sb.cell_px), pixels_for(sb.cell_px));
      end
    end

    settle();
    repeat (64) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[atlas_grid_first_fit_allocator_core.f]
hdl/agffa_pkg.sv
hdl/agffa_ifs.sv
hdl/agffa_front.sv
hdl/agffa_cmd_fifo.sv
hdl/agffa_back.sv
hdl/atlas_grid_first_fit_allocator_core.sv
hdl/agffa_checker.sv
test/testbench.sv
